/* design/gda_pkg.sv */
package gda_pkg;

  // Width of the day count carried in each request.
  localparam int DAY_COUNT_WIDTH = 16;

  localparam int DAY_WIDTH   = 5;
  localparam int MONTH_WIDTH = 4;
  localparam int YEAR_WIDTH  = 14;

  // The running day total has to hold the start day plus the whole count.
  localparam int ACC_WIDTH = DAY_COUNT_WIDTH + 1;

  localparam int IN_FIELD_BITS   = DAY_WIDTH + MONTH_WIDTH + YEAR_WIDTH + DAY_COUNT_WIDTH;
  localparam int IN_TDATA_WIDTH  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS  = DAY_WIDTH + MONTH_WIDTH + YEAR_WIDTH;
  localparam int OUT_TDATA_WIDTH = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [MONTH_WIDTH-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_WIDTH-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_WIDTH-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_WIDTH-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_WIDTH-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_WIDTH-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_WIDTH-1:0] MONTH_DEC = 4'd12;

  localparam logic [YEAR_WIDTH-1:0] YEAR_MAX    = {YEAR_WIDTH{1'b1}};
  localparam logic [YEAR_WIDTH-1:0] CYCLE_400   = 14'd400;
  localparam logic [YEAR_WIDTH-1:0] CYCLE_LAST  = 14'd399;
  localparam logic [YEAR_WIDTH-1:0] CENTURY_1   = 14'd100;
  localparam logic [YEAR_WIDTH-1:0] CENTURY_2   = 14'd200;
  localparam logic [YEAR_WIDTH-1:0] CENTURY_3   = 14'd300;

  typedef struct packed {
    logic load;         // capture a new request
    logic reduce_step;  // take 400 off the year remainder
    logic walk_step;    // step the date forward by one month
    logic result_load;  // copy the finished date to the output register
  } gda_cmd_t;

  typedef struct packed {
    logic reduce_done;  // year remainder is below 400
    logic walk_done;    // day total fits in the current month
  } gda_stat_t;

  // Length of a month outside a leap year; the month is always 1..12 here.
  function automatic logic [DAY_WIDTH-1:0] month_days(input logic [MONTH_WIDTH-1:0] month);
    logic [DAY_WIDTH-1:0] len;
    unique case (month)
      MONTH_FEB: len = 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* design/gda_dpath.sv */
module gda_dpath
  import gda_pkg::*;
(
  input  logic                       clk,
  input  logic [IN_TDATA_WIDTH-1:0]  in_data,
  input  gda_cmd_t                   cmd,
  output gda_stat_t                  stat,
  output logic [OUT_TDATA_WIDTH-1:0] out_data
);

  logic [ACC_WIDTH-1:0]   day;
  logic [MONTH_WIDTH-1:0] month;
  logic [YEAR_WIDTH-1:0]  year;
  logic [YEAR_WIDTH-1:0]  year_rem;

  logic [DAY_WIDTH-1:0]   res_day;
  logic [MONTH_WIDTH-1:0] res_month;
  logic [YEAR_WIDTH-1:0]  res_year;

  logic [DAY_WIDTH-1:0]       in_day;
  logic [MONTH_WIDTH-1:0]     in_month;
  logic [YEAR_WIDTH-1:0]      in_year;
  logic [DAY_COUNT_WIDTH-1:0] in_count;
  logic [MONTH_WIDTH-1:0]     in_month_norm;

  logic                 leap;
  logic [DAY_WIDTH-1:0] len;

  assign in_day   = in_data[DAY_WIDTH-1:0];
  assign in_month = in_data[DAY_WIDTH +: MONTH_WIDTH];
  assign in_year  = in_data[DAY_WIDTH+MONTH_WIDTH +: YEAR_WIDTH];
  assign in_count = in_data[DAY_WIDTH+MONTH_WIDTH+YEAR_WIDTH +: DAY_COUNT_WIDTH];

  // Month codes outside 1..12 are taken as January.
  assign in_month_norm = (in_month < MONTH_JAN || in_month > MONTH_DEC) ? MONTH_JAN : in_month;

  // year_rem is year mod 400, so a century year is one of 0, 100, 200, 300.
  assign leap = (year[1:0] == 2'b00) && (year_rem != CENTURY_1) &&
                (year_rem != CENTURY_2) && (year_rem != CENTURY_3);

  assign len = month_days(month) + DAY_WIDTH'((month == MONTH_FEB) && leap);

  assign stat.reduce_done = (year_rem < CYCLE_400);
  assign stat.walk_done   = (day <= ACC_WIDTH'(len));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day      <= ACC_WIDTH'(in_day) + ACC_WIDTH'(in_count);
      month    <= in_month_norm;
      year     <= in_year;
      year_rem <= in_year;
    end else if (cmd.reduce_step) begin
      year_rem <= year_rem - CYCLE_400;
    end else if (cmd.walk_step) begin
      day <= day - ACC_WIDTH'(len);
      if (month == MONTH_DEC) begin
        month <= MONTH_JAN;
        year  <= year + YEAR_WIDTH'(1);
        // When the year wraps to zero the remainder restarts with it.
        if (year == YEAR_MAX || year_rem == CYCLE_LAST) begin
          year_rem <= '0;
        end else begin
          year_rem <= year_rem + YEAR_WIDTH'(1);
        end
      end else begin
        month <= month + MONTH_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      res_day   <= day[DAY_WIDTH-1:0];
      res_month <= month;
      res_year  <= year;
    end
  end

  assign out_data = {{(OUT_TDATA_WIDTH-OUT_FIELD_BITS){1'b0}}, res_year, res_month, res_day};

endmodule

/* design/gda_ctrl.sv */
module gda_ctrl
  import gda_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  gda_stat_t stat,
  output gda_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REDUCE = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (stat.reduce_done) begin
          state_next = ST_WALK;
        end else begin
          cmd.reduce_step = 1'b1;
        end
      end
      ST_WALK: begin
        if (!stat.walk_done) begin
          cmd.walk_step = 1'b1;
        end else if (out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.reduce_step, cmd.walk_step, cmd.result_load}))
    else $error("more than one datapath command in a cycle");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |=> out_valid)
    else $error("finished date not presented");

  a_hold_finished: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && stat.walk_done && out_valid && !out_ready) |=> state == ST_WALK)
    else $error("finished date dropped while output stalled");

endmodule

/* design/gregorian_date_advance.sv */
// Channel  | Direction | Contents
// ---------+-----------+----------------------------------------------------
// s_*      | in        | request: start date and number of days to advance
// m_*      | out       | result: the advanced date, one per request
//
// A request is captured, then the year remainder is reduced modulo 400 by
// taking off 400 at a time, then the date is walked forward one month per
// cycle, one step for each month boundary crossed, and at last the finished
// date is copied to the output register.
// Reset is synchronous and clears only the controller and the output valid.
// A stalled output holds its date; the next request is taken as soon as the
// finished date has moved into the output register.
module gregorian_date_advance
  import gda_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // From bit 0 up: start_day, start_month, start_year, days_to_add, zero fill.
  input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // From bit 0 up: result_day, result_month, result_year, zero fill.
  output logic [OUT_TDATA_WIDTH-1:0] m_tdata
);

  gda_cmd_t  cmd;
  gda_stat_t stat;

  // The controller sequences the capture, the year reduction and the month
  // walk; it also owns the output valid flag.
  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath keeps the running day total, month, year and the year
  // remainder used for the century rule, and the output date register.
  gda_dpath u_dpath (
    .clk      (clk),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (m_tdata)
  );

endmodule

/* dv/gregorian_date_advance_checker.sv */
`timescale 1ns / 100ps

module gregorian_date_advance_checker
  import gda_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  // From bit 0 up: start_day, start_month, start_year, days_to_add, zero fill.
  input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  // From bit 0 up: result_day, result_month, result_year, zero fill.
  input  logic [OUT_TDATA_WIDTH-1:0] m_tdata,
  output int                         fail_count,
  output int                         outstanding
);

  typedef struct packed {
    logic [YEAR_WIDTH-1:0]  year;
    logic [MONTH_WIDTH-1:0] month;
    logic [DAY_WIDTH-1:0]   day;
  } date_t;

  date_t expected_dates[$];
  int    errors = 0;

  // Adds the day count to the start day, then takes off whole months until
  // the total fits in the month reached.
  function automatic date_t predict_date(input logic [IN_TDATA_WIDTH-1:0] request);
    int unsigned total;
    int unsigned month;
    int unsigned year;
    int unsigned len;
    bit          fits;
    date_t       next;
    month = 32'(request[DAY_WIDTH +: MONTH_WIDTH]);
    if (month < 32'(MONTH_JAN) || month > 32'(MONTH_DEC)) begin
      month = 32'(MONTH_JAN);
    end
    year  = 32'(request[DAY_WIDTH + MONTH_WIDTH +: YEAR_WIDTH]);
    total = 32'(request[DAY_WIDTH-1:0]);
    total = total + 32'(request[DAY_WIDTH + MONTH_WIDTH + YEAR_WIDTH +: DAY_COUNT_WIDTH]);
    fits  = 1'b0;
    while (!fits) begin
      if (month == 32'(MONTH_FEB)) begin
        len = (((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0) ? 29 : 28;
      end else if (month == 32'(MONTH_APR) || month == 32'(MONTH_JUN) ||
                   month == 32'(MONTH_SEP) || month == 32'(MONTH_NOV)) begin
        len = 30;
      end else begin
        len = 31;
      end
      if (total <= len) begin
        fits = 1'b1;
      end else begin
        total = total - len;
        month = month + 1;
        if (month > 32'(MONTH_DEC)) begin
          month = 32'(MONTH_JAN);
          year  = (year + 1) % (1 << YEAR_WIDTH);
        end
      end
    end
    next.day   = total[DAY_WIDTH-1:0];
    next.month = month[MONTH_WIDTH-1:0];
    next.year  = year[YEAR_WIDTH-1:0];
    return next;
  endfunction

  always @(posedge clk) begin
    date_t want;
    date_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_dates.push_back(predict_date(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[OUT_FIELD_BITS-1:0];
        if (expected_dates.size() == 0) begin
          $error("result with no request waiting: day %0d month %0d year %0d",
                 got.day, got.month, got.year);
          errors++;
        end else begin
          want = expected_dates.pop_front();
          if (got.day !== want.day) begin
            $error("result_day: expected %0d, actual %0d", want.day, got.day);
            errors++;
          end
          if (got.month !== want.month) begin
            $error("result_month: expected %0d, actual %0d", want.month, got.month);
            errors++;
          end
          if (got.year !== want.year) begin
            $error("result_year: expected %0d, actual %0d", want.year, got.year);
            errors++;
          end
        end
      end
    end
    fail_count  <= errors;
    outstanding <= expected_dates.size();
  end

endmodule

/* dv/gregorian_date_advance_tb.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the date adder. The checker instance beside the
// block watches both channels, predicts every result and counts mismatches;
// this module only makes requests, stalls the result side and decides.
module gregorian_date_advance_tb
  import gda_pkg::*;
();

  // The limit on quiet cycles lies far beyond the slowest request together
  // with a stall of the result side, so only a hung run can reach it.
  localparam int IDLE_LIMIT      = 20000;
  localparam int RANDOM_REQUESTS = 250;
  localparam int DRAIN_CYCLES    = 100;

  typedef enum {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_HOLD
  } stall_mode_t;

  logic                       clk      = 1'b0;
  logic                       rst      = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [IN_TDATA_WIDTH-1:0]  s_tdata  = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] m_tdata;

  int          fail_count;
  int          outstanding;
  int          idle_cycles = 0;
  int          burst_left  = 0;
  int          phase_left  = 0;
  stall_mode_t stall_mode  = READY_ALWAYS;
  logic        ready_next;

  always #4 clk = ~clk;

  gregorian_date_advance u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  gregorian_date_advance_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Offers one request and holds it until the block takes it. Requests go
  // out in bursts; once a burst is spent the valid drops for a gap, so that
  // it is never lowered and raised in one step.
  task automatic offer_request(input logic [DAY_WIDTH-1:0]       day,
                               input logic [MONTH_WIDTH-1:0]     month,
                               input logic [YEAR_WIDTH-1:0]      year,
                               input logic [DAY_COUNT_WIDTH-1:0] count);
    logic [IN_TDATA_WIDTH-1:0] word;
    word = '0;
    word[IN_FIELD_BITS-1:0] = {count, year, month, day};
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(0, 7);
    end
  endtask

  // The result side moves through phases of its own: always ready, ready on
  // a coin toss, ready one cycle in eight, and held off altogether for a
  // short while. The phases know nothing of the handshakes.
  always @(posedge clk) begin
    if (phase_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      phase_left = (stall_mode == READY_HOLD) ? $urandom_range(1, 60)
                                              : $urandom_range(20, 200);
    end
    phase_left--;
    case (stall_mode)
      READY_ALWAYS: begin
        ready_next = 1'b1;
      end
      READY_COIN: begin
        ready_next = 1'($urandom_range(0, 1));
      end
      READY_SPARSE: begin
        ready_next = (phase_left % 8) == 0;
      end
      default: begin
        ready_next = 1'b0;
      end
    endcase
    m_tready <= ready_next;
  end

  // Counts cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [DAY_WIDTH-1:0]       day;
    logic [MONTH_WIDTH-1:0]     month;
    logic [YEAR_WIDTH-1:0]      year;
    logic [DAY_COUNT_WIDTH-1:0] count;
    int                         pick;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed requests: ordinary dates, the month and year boundaries, the
    // leap rules including the century years and year zero, out-of-range
    // months, a zero day, days past the end of their month, the wrap of the
    // year counter and the largest counts.
    offer_request(5'd1,  MONTH_JAN, 14'd2000,  16'd0);
    offer_request(5'd0,  MONTH_JAN, 14'd2023,  16'd0);
    offer_request(5'd0,  4'd0,      14'd0,     16'd0);
    offer_request(5'd31, MONTH_APR, 14'd2021,  16'd0);
    offer_request(5'd31, MONTH_JUN, 14'd2022,  16'd0);
    offer_request(5'd29, MONTH_FEB, 14'd2023,  16'd0);
    offer_request(5'd15, 4'd0,      14'd2021,  16'd20);
    offer_request(5'd10, 4'd13,     14'd1999,  16'd40);
    offer_request(5'd3,  4'd15,     14'd1750,  16'd0);
    offer_request(5'd28, MONTH_FEB, 14'd2024,  16'd1);
    offer_request(5'd28, MONTH_FEB, 14'd1900,  16'd1);
    offer_request(5'd28, MONTH_FEB, 14'd2000,  16'd1);
    offer_request(5'd28, MONTH_FEB, 14'd0,     16'd1);
    offer_request(5'd31, MONTH_DEC, 14'd1999,  16'd1);
    offer_request(5'd30, MONTH_NOV, 14'd2023,  16'd366);
    offer_request(5'd31, MONTH_DEC, YEAR_MAX,  16'd1);
    offer_request(5'd1,  MONTH_JAN, 14'd16000, 16'd30000);
    offer_request(5'd1,  MONTH_JAN, 14'd1,     16'hFFFF);
    offer_request(5'd31, MONTH_DEC, 14'd9999,  16'hFFFF);
    offer_request(5'd31, 4'd15,     YEAR_MAX,  16'hFFFF);
    offer_request(5'd17, MONTH_SEP, 14'd8191,  16'd1000);

    // Random requests. Most are plausible dates with modest counts; a share
    // reaches for the full field ranges and the longest walks.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      day   = DAY_WIDTH'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(1, 31));
      month = MONTH_WIDTH'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(1, 12));
      year  = YEAR_WIDTH'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383)
                                                      : $urandom_range(1, 9999));
      pick  = $urandom_range(0, 99);
      if (pick < 50) begin
        count = DAY_COUNT_WIDTH'($urandom_range(0, 60));
      end else if (pick < 80) begin
        count = DAY_COUNT_WIDTH'($urandom_range(0, 1500));
      end else if (pick < 95) begin
        count = DAY_COUNT_WIDTH'($urandom_range(0, 65535));
      end else begin
        count = DAY_COUNT_WIDTH'($urandom_range(60000, 65535));
      end
      offer_request(day, month, year, count);
    end

    // Let the last results come home, then watch a while for stray ones.
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
